### rtl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, off during reset.
`define SACT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Same check, but also held during reset.
`define SACT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

### rtl/sact_pkg.sv
// Package for the set-associative tag lookup: defaults, codes, state type.
// Used by every module of the block.
`timescale 1ns / 1ps
package sact_pkg;

  localparam int DEF_WAYS       = 4;
  localparam int DEF_SETS       = 256;
  localparam int DEF_ADDR_WIDTH = 32;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic [2:0] REG_POLICY      = 3'd0;
  localparam logic [2:0] REG_WAYS_IN_USE = 3'd1;
  localparam logic [2:0] REG_SET_BITS    = 3'd2;
  localparam logic [2:0] REG_BLOCK_BITS  = 3'd3;

  localparam logic POLICY_LFU = 1'b0;
  localparam logic POLICY_LRU = 1'b1;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_SCAN,
    B_WRITE
  } back_state_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } sact_status_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == SAT32) ? v : v + 32'd1;
  endfunction

endpackage

### rtl/set_assoc_cache_tag_lookup.sv
// Set-associative tag lookup with LFU/LRU replacement, top level.
// Depends on sact_pkg, sact_front, sact_queue, sact_back, assert_macros.svh.
//
// Each address transaction is split into set and tag by the front end, parked
// in a two-entry queue, and resolved by the back end, which reads the whole
// set row from the tag store, scans the ways in use one per cycle (first
// matching valid way hits; LFU picks the first smallest use count, LRU the
// last smallest stamp), then writes the row back and loads the result
// register. Each access runs through a row read, a serial scan of w ways (w
// being ways_in_use held to the range 1..WAYS) and a write-back, which waits
// while the result register is full; the back end takes no new transaction
// before it is through with the last. Results queue in a one-deep output
// register; the front keeps taking transactions while it is full, until the
// queue fills. After reset the store is cleared one set per cycle, with full
// held high; configuration writes are taken at all times (cfg_ready is
// always high) and should only be issued while the block is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module set_assoc_cache_tag_lookup import sact_pkg::*; #(
  parameter int WAYS       = DEF_WAYS,
  parameter int SETS       = DEF_SETS,
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [ADDR_WIDTH-1:0] address,
  output logic                  empty,
  input  logic                  pop,
  output logic                  hit,
  output logic [1:0]            way,
  output logic [7:0]            set_index,
  output logic [31:0]           hit_count,
  output logic [31:0]           miss_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCNT_W = $clog2(WAYS + 1);

  // configuration registers
  logic       policy;
  logic [2:0] ways_in_use;
  logic [3:0] set_bits;
  logic [4:0] block_bits;
  logic [WCNT_W-1:0] ways_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= POLICY_LRU;
      ways_in_use <= 3'd4;
      set_bits    <= 4'd8;
      block_bits  <= 5'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POLICY:      policy      <= cfg_data[0];
        REG_WAYS_IN_USE: ways_in_use <= cfg_data[2:0];
        REG_SET_BITS:    set_bits    <= cfg_data[3:0];
        REG_BLOCK_BITS:  block_bits  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // zero ways act as one, too many act as WAYS
  always_comb begin
    if (ways_in_use == 3'd0) begin
      ways_eff = WCNT_W'(1);
    end else if (32'(ways_in_use) > WAYS) begin
      ways_eff = WCNT_W'(WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_in_use);
    end
  end

  sact_status_t          status;
  logic                  q_wr, q_rd, q_full, q_empty;
  logic [SET_W-1:0]      f_set, b_set;
  logic [ADDR_WIDTH-1:0] f_tag, b_tag;

  sact_front #(
    .SETS(SETS), .ADDR_WIDTH(ADDR_WIDTH), .SET_W(SET_W)
  ) u_front (
    .push(push), .full(full), .address(address),
    .set_bits(set_bits), .block_bits(block_bits), .status(status),
    .q_full(q_full), .q_wr(q_wr), .q_set(f_set), .q_tag(f_tag)
  );

  sact_queue #(
    .W(SET_W + ADDR_WIDTH)
  ) u_queue (
    .clk(clk), .rst(rst), .wr(q_wr), .wdata({f_set, f_tag}),
    .rd(q_rd), .rdata({b_set, b_tag}), .full(q_full), .empty(q_empty)
  );

  sact_back #(
    .WAYS(WAYS), .SETS(SETS), .ADDR_WIDTH(ADDR_WIDTH),
    .SET_W(SET_W), .WAY_W(WAY_W), .WCNT_W(WCNT_W)
  ) u_back (
    .clk(clk), .rst(rst), .policy(policy), .ways_eff(ways_eff),
    .q_empty(q_empty), .q_set(b_set), .q_tag(b_tag), .q_rd(q_rd),
    .status(status), .pop(pop), .empty(empty), .hit(hit), .way(way),
    .set_index(set_index), .hit_count(hit_count), .miss_count(miss_count)
  );

  // no address transaction gets in during the clearing pass
  `SACT_ASSERT_ALWAYS(a_no_push_clear, status.clearing |-> full)
  // a shown hit has been counted, and so has a shown miss
  `SACT_ASSERT(a_hit_counted, (!empty && hit) |-> (hit_count != 32'd0))
  `SACT_ASSERT(a_miss_counted, (!empty && !hit) |-> (miss_count != 32'd0))
  // a result waiting means the back end reports busy
  `SACT_ASSERT(a_busy, !empty |-> status.busy)
endmodule

### rtl/sact_queue.sv
// Two-entry queue between the lookup front end and the back end.
// Uses sact_pkg only by convention of the project.
`timescale 1ns / 1ps
module sact_queue import sact_pkg::*; #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  logic [W-1:0] slot [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (rd) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wptr] <= wdata;
    end
  end

  assign rdata = slot[rptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
endmodule

### rtl/sact_front.sv
// Front end: takes address transactions and splits them into set and tag.
// Depends on sact_pkg; feeds sact_queue.
`timescale 1ns / 1ps
module sact_front import sact_pkg::*; #(
  parameter int SETS       = DEF_SETS,
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH,
  parameter int SET_W      = 8
) (
  input  logic                  push,
  output logic                  full,
  input  logic [ADDR_WIDTH-1:0] address,
  input  logic [3:0]            set_bits,
  input  logic [4:0]            block_bits,
  input  sact_status_t          status,
  input  logic                  q_full,
  output logic                  q_wr,
  output logic [SET_W-1:0]      q_set,
  output logic [ADDR_WIDTH-1:0] q_tag
);
  localparam int MSB = $clog2(SETS + 1) - 1;  // floor log2

  logic [3:0]       sb_eff;
  logic [5:0]       shamt;
  logic [SET_W-1:0] set_mask;
  logic [ADDR_WIDTH-1:0] above_off;

  always_comb begin
    sb_eff    = (32'(set_bits) > MSB) ? 4'(MSB) : set_bits;
    shamt     = 6'(sb_eff) + 6'(block_bits);
    set_mask  = {SET_W{1'b1}} >> (SET_W - int'(sb_eff));
    above_off = address >> block_bits;
    q_set     = above_off[SET_W-1:0] & set_mask;
    q_tag     = address >> shamt;
  end

  assign full = q_full | status.clearing;
  assign q_wr = push & ~full;
endmodule

### rtl/sact_back.sv
// Back end: tag store, serial way scan, replacement and result register.
// Depends on sact_pkg; reads from sact_queue.
`timescale 1ns / 1ps
module sact_back import sact_pkg::*; #(
  parameter int WAYS       = DEF_WAYS,
  parameter int SETS       = DEF_SETS,
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH,
  parameter int SET_W      = 8,
  parameter int WAY_W      = 2,
  parameter int WCNT_W     = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  policy,
  input  logic [WCNT_W-1:0]     ways_eff,
  input  logic                  q_empty,
  input  logic [SET_W-1:0]      q_set,
  input  logic [ADDR_WIDTH-1:0] q_tag,
  output logic                  q_rd,
  output sact_status_t          status,
  input  logic                  pop,
  output logic                  empty,
  output logic                  hit,
  output logic [1:0]            way,
  output logic [7:0]            set_index,
  output logic [31:0]           hit_count,
  output logic [31:0]           miss_count
);
  localparam int CLR_W = $clog2(SETS + 1);

  logic [WAYS-1:0]                  mem_valid [SETS];
  logic [WAYS-1:0][31:0]            mem_use   [SETS];
  logic [WAYS-1:0][ADDR_WIDTH-1:0]  mem_tag   [SETS];

  logic [WAYS-1:0]                  rd_valid;
  logic [WAYS-1:0][31:0]            rd_use;
  logic [WAYS-1:0][ADDR_WIDTH-1:0]  rd_tag;

  back_state_t state, state_next;
  logic [CLR_W-1:0]      clr_cnt;
  logic [SET_W-1:0]      cur_set;
  logic [ADDR_WIDTH-1:0] cur_tag;
  logic [WAY_W-1:0]      scan;
  logic                  found;
  logic [WAY_W-1:0]      hit_way;
  logic [31:0]           best;
  logic [WAY_W-1:0]      best_way;
  logic [31:0]           access_time;
  logic                  out_valid;

  logic                  last_way;
  logic                  out_free;
  logic [WAY_W-1:0]      tw;
  logic [31:0]           new_use;
  logic                  assoc;
  logic                  take;

  assign last_way = (WCNT_W'(scan) == ways_eff - WCNT_W'(1));
  assign out_free = ~out_valid | pop;
  assign assoc    = (ways_eff > WCNT_W'(1));
  assign take     = (state == B_IDLE) && !q_empty;

  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: if (clr_cnt == CLR_W'(SETS - 1)) state_next = B_IDLE;
      B_IDLE:  if (!q_empty) state_next = B_SCAN;
      B_SCAN:  if (last_way) state_next = B_WRITE;
      B_WRITE: if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_rd            = take;
    status.clearing = (state == B_CLEAR);
    status.busy     = (state != B_IDLE) || out_valid;
  end

  always_comb begin
    if (found) begin
      tw = hit_way;
    end else begin
      tw = assoc ? best_way : '0;
    end
    if (found) begin
      new_use = (policy == POLICY_LRU) ? access_time : sat_inc(rd_use[tw]);
    end else begin
      new_use = (policy == POLICY_LRU) ? access_time : 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // tag store: cleared row by row after reset, one row per set
  always_ff @(posedge clk) begin
    if (state == B_CLEAR) begin
      mem_valid[clr_cnt[SET_W-1:0]] <= '0;
      mem_use[clr_cnt[SET_W-1:0]]   <= '0;
      mem_tag[clr_cnt[SET_W-1:0]]   <= '0;
    end else if (state == B_WRITE && out_free) begin
      mem_valid[cur_set] <= rd_valid | (found ? '0 : (WAYS'(1) << tw));
      for (int i = 0; i < WAYS; i++) begin
        if (WAY_W'(i) == tw) begin
          mem_use[cur_set][i] <= assoc ? new_use : rd_use[i];
          mem_tag[cur_set][i] <= found ? rd_tag[i] : cur_tag;
        end else begin
          mem_use[cur_set][i] <= rd_use[i];
          mem_tag[cur_set][i] <= rd_tag[i];
        end
      end
    end
    if (take) begin
      rd_valid <= mem_valid[q_set];
      rd_use   <= mem_use[q_set];
      rd_tag   <= mem_tag[q_set];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt     <= '0;
      access_time <= 32'd1;
      hit_count   <= '0;
      miss_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == B_CLEAR) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (state == B_WRITE && out_free) begin
        out_valid   <= 1'b1;
        access_time <= sat_inc(access_time);
        if (found) begin
          hit_count <= sat_inc(hit_count);
        end else begin
          miss_count <= sat_inc(miss_count);
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_set <= q_set;
      cur_tag <= q_tag;
      scan    <= '0;
      found   <= 1'b0;
    end else if (state == B_SCAN) begin
      scan <= scan + WAY_W'(1);
      if (!found && rd_valid[scan] && rd_tag[scan] == cur_tag) begin
        found   <= 1'b1;
        hit_way <= scan;
      end
      if (scan == '0 ||
          ((policy == POLICY_LFU) ? (rd_use[scan] < best) : (rd_use[scan] <= best))) begin
        best     <= rd_use[scan];
        best_way <= scan;
      end
    end
    if (state == B_WRITE && out_free) begin
      hit       <= found;
      way       <= 2'(tw);
      set_index <= 8'(cur_set);
    end
  end

  assign empty = ~out_valid;
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for set_assoc_cache_tag_lookup: directed table, then random phases.
// Depends on sact_pkg and the block's RTL; checks each result against its own tag-store model.
module tb_top;
  import sact_pkg::*;

  localparam int N_WAYS     = 4;
  localparam int N_SETS     = 256;
  localparam int MAX_SB     = 8;
  localparam int DRAIN      = 24;       // idle tail that quiesce waits out after the last expected result
  localparam int CYCLE_CAP  = 2000000;
  localparam int N_PHASES   = 13;
  localparam int PHASE_LEN  = 150;

  typedef struct packed {
    logic        hit;
    logic [1:0]  way;
    logic [7:0]  set_index;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
  } lookup_t;

  // directed row: address plus, where obvious, the hit/way/set it must give
  typedef struct {
    logic [31:0] addr;
    bit          known;
    logic        hit;
    logic [1:0]  way;
    logic [7:0]  set_index;
  } probe_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [31:0] address = '0;
  logic        pop = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = REG_POLICY;
  logic [31:0] cfg_data = '0;
  logic        full, empty, hit, cfg_ready;
  logic [1:0]  way;
  logic [7:0]  set_index;
  logic [31:0] hit_count, miss_count;

  set_assoc_cache_tag_lookup dut (
    .clk, .rst, .push, .full, .address, .empty, .pop, .hit, .way, .set_index,
    .hit_count, .miss_count, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // model state: mirrors tag store, use values and totals
  logic        cfg_policy;
  logic [2:0]  cfg_ways;
  logic [3:0]  cfg_set_bits;
  logic [4:0]  cfg_block_bits;
  logic        line_ok  [N_SETS*N_WAYS];
  logic [31:0] line_tg  [N_SETS*N_WAYS];
  logic [31:0] line_use [N_SETS*N_WAYS];
  logic [31:0] stamp;
  logic [31:0] hits_so_far, misses_so_far;

  lookup_t pending[$];
  int      errors = 0;
  int      cycles = 0;

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // one access against the model; updates state, returns the expected result
  function automatic lookup_t access_line(input logic [31:0] a);
    int          nw, sb, base, sel;
    logic [63:0] tg;
    logic [31:0] set_no, best;
    bit          found;
    lookup_t     r;
    nw = (cfg_ways == 0) ? 1 : (cfg_ways > N_WAYS) ? N_WAYS : int'(cfg_ways);
    sb = (cfg_set_bits > MAX_SB) ? MAX_SB : int'(cfg_set_bits);
    tg = {32'd0, a} >> (sb + cfg_block_bits);
    set_no = (a >> cfg_block_bits) & ((32'd1 << sb) - 32'd1);
    base = int'(set_no) * N_WAYS;
    found = 0;
    sel = 0;
    for (int i = 0; i < nw; i++) begin
      if (!found && line_ok[base+i] && {32'd0, line_tg[base+i]} == tg) begin
        found = 1;
        sel = i;
      end
    end
    if (found) begin
      hits_so_far = bump(hits_so_far);
      if (nw > 1)
        line_use[base+sel] = (cfg_policy == POLICY_LFU) ? bump(line_use[base+sel]) : stamp;
    end else begin
      misses_so_far = bump(misses_so_far);
      if (nw > 1) begin
        best = line_use[base];
        for (int i = 1; i < nw; i++) begin
          // LFU keeps the first smallest, LRU moves to the last smallest
          if ((cfg_policy == POLICY_LFU) ? (line_use[base+i] < best)
                                         : (line_use[base+i] <= best)) begin
            best = line_use[base+i];
            sel = i;
          end
        end
        line_use[base+sel] = (cfg_policy == POLICY_LFU) ? 32'd1 : stamp;
      end
      line_ok[base+sel] = 1'b1;
      line_tg[base+sel] = tg[31:0];
    end
    stamp = bump(stamp);
    r.hit = found;
    r.way = sel[1:0];
    r.set_index = set_no[7:0];
    r.hit_count = hits_so_far;
    r.miss_count = misses_so_far;
    return r;
  endfunction

  task automatic idle_gap(output int n);
    // mostly short, now and then long
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endtask

  // one write per call; valid drops for a cycle before the next one
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_POLICY:      cfg_policy     = val[0];
      REG_WAYS_IN_USE: cfg_ways       = val[2:0];
      REG_SET_BITS:    cfg_set_bits   = val[3:0];
      REG_BLOCK_BITS:  cfg_block_bits = val[4:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // waits out every expected result, then the back end's tail
  task automatic quiesce();
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // sends one address transaction; optional override of the obvious fields
  task automatic send(input logic [31:0] a, input bit known, input probe_t row);
    lookup_t e;
    int      g;
    push    <= 1'b1;
    address <= a;
    @(posedge clk);
    while (full) @(posedge clk);
    e = access_line(a);
    if (known) begin
      e.hit = row.hit;
      e.way = row.way;
      e.set_index = row.set_index;
    end
    pending.push_back(e);
    idle_gap(g);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // result side: random pop stalls, checks each transaction in order
  initial begin
    lookup_t e;
    int      g;
    forever begin
      idle_gap(g);
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      if (pop && !empty) begin
        if (pending.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = pending.pop_front();
          if (hit !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, hit); errors++;
          end
          if (way !== e.way) begin
            $error("way: expected %0d, got %0d", e.way, way); errors++;
          end
          if (set_index !== e.set_index) begin
            $error("set_index: expected %0d, got %0d", e.set_index, set_index); errors++;
          end
          if (hit_count !== e.hit_count) begin
            $error("hit_count: expected %0d, got %0d", e.hit_count, hit_count); errors++;
          end
          if (miss_count !== e.miss_count) begin
            $error("miss_count: expected %0d, got %0d", e.miss_count, miss_count);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    probe_t      dirs[$];
    probe_t      row;
    logic [31:0] hot[16];
    logic [63:0] a64;
    int          sb, bb;
    // reset-state model
    cfg_policy = POLICY_LRU; cfg_ways = 3'd4; cfg_set_bits = 4'd8; cfg_block_bits = 5'd4;
    for (int i = 0; i < N_SETS*N_WAYS; i++) begin
      line_ok[i] = 1'b0; line_tg[i] = '0; line_use[i] = '0;
    end
    stamp = 32'd1; hits_so_far = '0; misses_so_far = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // store clear runs with full held high
    @(posedge clk);
    while (full) @(posedge clk);

    // defaults: LRU, 4 ways, 256 sets, 16-byte blocks; empty set fills way 3 first
    dirs = '{
      '{32'h0000_0000, 1, 1'b0, 2'd3, 8'd0},
      '{32'h0000_000F, 1, 1'b1, 2'd3, 8'd0},
      '{32'hFFFF_FFFF, 1, 1'b0, 2'd3, 8'd255},
      '{32'hFFFF_FFF0, 1, 1'b1, 2'd3, 8'd255},
      '{32'h0000_1000, 1, 1'b0, 2'd2, 8'd0},
      '{32'h0000_2000, 1, 1'b0, 2'd1, 8'd0},
      '{32'h0000_3000, 1, 1'b0, 2'd0, 8'd0},
      '{32'h0000_0004, 0, 1'b0, 2'd0, 8'd0},
      '{32'h0000_4000, 0, 1'b0, 2'd0, 8'd0},   // evicts the stalest line
      '{32'h0000_1000, 0, 1'b0, 2'd0, 8'd0},
      '{32'h8000_0010, 1, 1'b0, 2'd3, 8'd1},
      '{32'h5555_5555, 0, 1'b0, 2'd0, 8'd0},
      '{32'hAAAA_AAAA, 0, 1'b0, 2'd0, 8'd0}
    };
    foreach (dirs[i]) send(dirs[i].addr, dirs[i].known, dirs[i]);
    push <= 1'b0;
    quiesce();

    // LFU, direct mapped via ways 0, and wide offsets with oversized set field
    write_reg(REG_POLICY, POLICY_LFU);
    write_reg(REG_WAYS_IN_USE, 32'd0);
    write_reg(REG_SET_BITS, 32'd15);
    write_reg(REG_BLOCK_BITS, 32'd31);
    row = dirs[0];
    foreach (dirs[i]) send(dirs[i].addr, 0, row);
    push <= 1'b0;
    quiesce();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(REG_POLICY, POLICY_LFU); write_reg(REG_WAYS_IN_USE, 32'd4);
          write_reg(REG_SET_BITS, 32'd0);    write_reg(REG_BLOCK_BITS, 32'd0);
        end
        1: begin
          write_reg(REG_POLICY, POLICY_LRU); write_reg(REG_WAYS_IN_USE, 32'd7);
          write_reg(REG_SET_BITS, 32'd8);    write_reg(REG_BLOCK_BITS, 32'd16);
        end
        2: begin
          write_reg(REG_POLICY, POLICY_LFU); write_reg(REG_WAYS_IN_USE, 32'd1);
          write_reg(REG_SET_BITS, 32'd2);    write_reg(REG_BLOCK_BITS, 32'd4);
        end
        default: begin
          write_reg(REG_POLICY, $urandom_range(0, 1));
          write_reg(REG_WAYS_IN_USE, $urandom_range(0, 7));
          write_reg(REG_SET_BITS, $urandom_range(0, 15));
          write_reg(REG_BLOCK_BITS, $urandom_range(0, 31));
        end
      endcase
      sb = (cfg_set_bits > MAX_SB) ? MAX_SB : int'(cfg_set_bits);
      bb = cfg_block_bits;
      // small hot set: few sets, few tags, so lines collide and get reused
      foreach (hot[i]) begin
        a64 = ({32'd0, $urandom_range(0, 7)} << (sb + bb)) |
              ({32'd0, $urandom_range(0, 3)} << bb);
        hot[i] = a64[31:0];
      end
      for (int k = 0; k < PHASE_LEN; k++) begin
        if ($urandom_range(0, 3) == 0)
          send($urandom, 0, row);
        else
          send(hot[$urandom_range(0, 15)] | ($urandom & ((32'd1 << bb) - 32'd1)), 0, row);
      end
      push <= 1'b0;
      quiesce();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
